>>> rtl/osd_pkg.sv
`default_nettype none
package osd_pkg;

  localparam int unsigned ScreenCells = 480;
  localparam int unsigned RowLength   = 30;
  localparam int unsigned AddrW       = $clog2(ScreenCells);
  localparam int unsigned CntW        = $clog2(ScreenCells + 1);
  localparam logic [15:0] BlankCell   = 16'h2000;
  localparam logic [7:0]  ExtFlag     = 8'h04;
  localparam logic [7:0]  Mode8Bit    = 8'h40;
  localparam logic [7:0]  ModeAttrMsk = 8'h38;
  localparam logic [3:0]  DrawMax     = 4'd10;

  typedef enum logic [2:0] {
    OpWrite   = 3'd0,
    OpRead    = 3'd1,
    OpClear   = 3'd2,
    OpRefresh = 3'd3,
    OpDraw    = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    StIdle,
    StAccess,
    StFinish,
    StScanRd,
    StScanEval,
    StInit
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic             latch;    // capture input item
    logic             mem_rd;   // read cell at addr
    logic [AddrW-1:0] addr;
    logic             do_write; // evaluate write op
    logic             do_read;  // emit read result
    logic             scan_op;  // evaluate scan element at addr
    logic             init_wr;  // write blank at addr
    logic             emit_simple; // emit status-only / range result
    logic             emit_none;   // draw with nothing dirty
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;
    logic draw_hit;    // current scan cell emits an update
    logic last_dirty;  // exactly one dirty cell is left
    logic [2:0] op;
  } dp_stat_t;

  function automatic logic is_blank(input logic [15:0] v);
    return ((v[15:8] == 8'h20) || (v[15:8] == 8'h00)) && ((v[7:0] & ExtFlag) == 8'h00);
  endfunction

endpackage
`default_nettype wire

>>> rtl/osd_datapath.sv
`default_nettype none
module osd_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [2:0]            opcode_i,
  input  wire logic [4:0]            column_i,
  input  wire logic [4:0]            row_i,
  input  wire logic [8:0]            char_code_i,
  input  wire logic [7:0]            attr_in_i,
  input  wire osd_pkg::dp_cmd_t      cmd_i,
  input  wire logic                  last_i,
  output osd_pkg::dp_stat_t          stat_o,
  output logic [osd_pkg::AddrW-1:0]  pos_o,
  output logic                       strobe_o,
  output logic                       status_o,
  output logic [8:0]                 char_out_o,
  output logic [7:0]                 attr_out_o,
  output logic                       update_valid_o,
  output logic                       mode_write_o,
  output logic [7:0]                 mode_value_o,
  output logic                       extended_write_o,
  output logic                       cell_addr_high_o,
  output logic [7:0]                 cell_addr_low_o,
  output logic [7:0]                 attr_byte_o,
  output logic [7:0]                 char_low_o,
  output logic                       last_o
);
  import osd_pkg::*;

  logic [15:0] mem_q [ScreenCells];
  logic        dirty_q [ScreenCells];
  logic [15:0] rd_q;
  logic        rd_dirty_q;
  logic [2:0]  op_q;
  logic [9:0]  pos_q;
  logic [15:0] wval_q;
  logic [7:0]  mode_q, mode_d;
  logic [9:0]  pos_full;
  logic        in_range;
  logic [CntW-1:0] dcnt_q;

  // position math, 5 bit row times constant
  assign pos_full = 10'(row_i * RowLength) + 10'(column_i);
  assign in_range = pos_q < 10'(ScreenCells);
  assign pos_o    = pos_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= opcode_i;
      pos_q  <= pos_full;
      wval_q <= {char_code_i[7:0], attr_in_i | (char_code_i[8] ? ExtFlag : 8'h00)};
    end
    if (cmd_i.mem_rd) begin
      rd_q       <= mem_q[cmd_i.addr];
      rd_dirty_q <= dirty_q[cmd_i.addr];
    end
  end

  // draw decision on the fetched cell
  logic       hit;
  logic       mw;
  logic       ext;
  assign hit = rd_dirty_q && (op_q == OpDraw);
  assign ext = (rd_q[7:0] & ExtFlag) != 8'h00;
  always_comb begin
    mode_d = mode_q;
    mw     = 1'b0;
    if (ext) begin
      if ((mode_q & Mode8Bit) == 8'h00) begin
        mode_d = mode_q | Mode8Bit;
        mw     = 1'b1;
      end
    end else if (((mode_q & Mode8Bit) != 8'h00) || ((mode_q & ModeAttrMsk) != rd_q[7:0])) begin
      mode_d = (mode_q & ~(Mode8Bit | ModeAttrMsk)) | rd_q[7:0];
      mw     = 1'b1;
    end
  end

  assign stat_o.in_range   = in_range;
  assign stat_o.draw_hit   = hit;
  assign stat_o.last_dirty = dcnt_q == CntW'(1);
  assign stat_o.op         = op_q;

  // store and dirty updates
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      mem_q[cmd_i.addr]   <= BlankCell;
      dirty_q[cmd_i.addr] <= 1'b0;
    end else if (cmd_i.do_write) begin
      if (rd_q != wval_q) begin
        mem_q[cmd_i.addr]   <= wval_q;
        dirty_q[cmd_i.addr] <= 1'b1;
      end
    end else if (cmd_i.scan_op) begin
      case (op_q)
        OpClear: begin
          if (rd_q != BlankCell) begin
            mem_q[cmd_i.addr]   <= BlankCell;
            dirty_q[cmd_i.addr] <= 1'b1;
          end
        end
        OpRefresh: dirty_q[cmd_i.addr] <= !is_blank(rd_q);
        OpDraw:    if (hit) dirty_q[cmd_i.addr] <= 1'b0;
        default: ;
      endcase
    end
  end

  // number of dirty cells, marks the final update of a draw
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.do_write) begin
      if ((rd_q != wval_q) && !rd_dirty_q) dcnt_q <= dcnt_q + 1'b1;
    end else if (cmd_i.scan_op) begin
      case (op_q)
        OpClear: if ((rd_q != BlankCell) && !rd_dirty_q) dcnt_q <= dcnt_q + 1'b1;
        OpRefresh: begin
          if (!is_blank(rd_q) && !rd_dirty_q) dcnt_q <= dcnt_q + 1'b1;
          else if (is_blank(rd_q) && rd_dirty_q) dcnt_q <= dcnt_q - 1'b1;
        end
        OpDraw: if (hit) dcnt_q <= dcnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 8'h00;
    end else if (cmd_i.scan_op && hit) begin
      mode_q <= mode_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= cmd_i.emit_simple || cmd_i.do_read || cmd_i.emit_none ||
                  (cmd_i.scan_op && hit);
    end
  end

  always_ff @(posedge clk_i) begin
    status_o <= 1'b0; char_out_o <= '0; attr_out_o <= '0; update_valid_o <= 1'b0;
    mode_write_o <= 1'b0; mode_value_o <= '0; extended_write_o <= 1'b0;
    cell_addr_high_o <= 1'b0; cell_addr_low_o <= '0; attr_byte_o <= '0;
    char_low_o <= '0; last_o <= last_i;
    if (cmd_i.emit_simple) begin
      status_o <= ((op_q == OpWrite) || (op_q == OpRead)) && !in_range;
    end else if (cmd_i.do_read) begin
      char_out_o <= {ext, rd_q[15:8]};
      attr_out_o <= rd_q[7:0] & ~ExtFlag;
    end else if (cmd_i.scan_op && hit) begin
      update_valid_o   <= 1'b1;
      mode_write_o     <= mw;
      mode_value_o     <= mw ? mode_d : 8'h00;
      extended_write_o <= ext;
      attr_byte_o      <= ext ? {rd_q[5:0], 2'b00} : 8'h00;
      cell_addr_high_o <= 1'(10'(cmd_i.addr) >> 8);
      cell_addr_low_o  <= 8'(10'(cmd_i.addr));
      char_low_o       <= rd_q[15:8];
    end
  end

endmodule
`default_nettype wire

>>> rtl/osd_ctrl.sv
`default_nettype none
module osd_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [3:0]            cfg_wdata_i,
  input  wire osd_pkg::dp_stat_t     stat_i,
  input  wire logic [osd_pkg::AddrW-1:0] pos_i,
  output osd_pkg::dp_cmd_t           cmd_o,
  output logic                       last_o,
  output logic                       busy_o
);
  import osd_pkg::*;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [3:0]        upd_q, limit;
  logic              at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) upd_q <= DrawMax;
    else if (cfg_we_i) upd_q <= cfg_wdata_i;
  end

  assign limit  = (upd_q == 4'd0) ? 4'd1 : ((upd_q > DrawMax) ? DrawMax : upd_q);
  assign at_end = idx_q == AddrW'(ScreenCells - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    last_o  = 1'b0;
    busy_o  = 1'b1;
    case (state_q)
      StInit: begin
        cmd_o.init_wr = 1'b1;
        cmd_o.addr    = idx_q;
        idx_d         = idx_q + 1'b1;
        if (at_end) begin
          idx_d   = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StAccess;
        end
      end
      StAccess: begin
        idx_d = '0;
        cnt_d = '0;
        if (stat_i.op == OpWrite || stat_i.op == OpRead) begin
          if (stat_i.in_range) begin
            cmd_o.mem_rd = 1'b1;
            cmd_o.addr   = pos_i;
            state_d      = StFinish;
          end else begin
            cmd_o.emit_simple = 1'b1;
            last_o  = 1'b1;
            state_d = StIdle;
          end
        end else if (stat_i.op == OpClear || stat_i.op == OpRefresh ||
                     stat_i.op == OpDraw) begin
          state_d = StScanRd;
        end else begin
          cmd_o.emit_simple = 1'b1;
          last_o  = 1'b1;
          state_d = StIdle;
        end
      end
      StFinish: begin
        cmd_o.addr = pos_i;
        last_o     = 1'b1;
        if (stat_i.op == OpWrite) begin
          cmd_o.do_write    = 1'b1;
          cmd_o.emit_simple = 1'b1;
        end else begin
          cmd_o.do_read = 1'b1;
        end
        state_d = StIdle;
      end
      StScanRd: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.addr   = idx_q;
        state_d      = StScanEval;
      end
      StScanEval: begin
        cmd_o.scan_op = 1'b1;
        cmd_o.addr    = idx_q;
        idx_d         = idx_q + 1'b1;
        state_d       = StScanRd;
        if (stat_i.draw_hit) begin
          cnt_d = cnt_q + 1'b1;
          if (at_end || cnt_d == limit || stat_i.last_dirty) begin
            last_o  = 1'b1;
            state_d = StIdle;
          end
        end else if (at_end) begin
          state_d = StIdle;
          if (stat_i.op == OpDraw) begin
            if (cnt_q == 4'd0) cmd_o.emit_none = 1'b1;
            else cmd_o.emit_none = 1'b0;
            last_o = 1'b1;
            if (cnt_q != 4'd0) state_d = StIdle;
          end else begin
            cmd_o.emit_simple = 1'b1;
            last_o = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/osd_dirty_cell_update_engine_unit.sv
`default_nettype none
// Character-cell screen store with dirty bits. Raise start while busy is
// low; every result appears for exactly one cycle with done_o high, the final
// one with last_o, and the receiver cannot hold results off. Write and read
// go through the access and finish states, or end in the access state when
// the position is out of range; clear, refresh and draw scan the store,
// reading and then evaluating each cell, and a draw stops early once
// updates_per_draw (clamped to 1 through 10) cells or all dirty cells are
// sent. After reset a clearing pass blanks all 480 cells while busy is high.
module osd_dirty_cell_update_engine_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] updates_per_draw_i,
  input  wire logic [2:0] opcode_i,
  input  wire logic [4:0] column_i,
  input  wire logic [4:0] row_i,
  input  wire logic [8:0] char_code_i,
  input  wire logic [7:0] attr_in_i,
  output logic            done_o,
  output logic            status_o,
  output logic [8:0]      char_out_o,
  output logic [7:0]      attr_out_o,
  output logic            update_valid_o,
  output logic            mode_write_o,
  output logic [7:0]      mode_value_o,
  output logic            extended_write_o,
  output logic            cell_addr_high_o,
  output logic [7:0]      cell_addr_low_o,
  output logic [7:0]      attr_byte_o,
  output logic [7:0]      char_low_o,
  output logic            last_o
);
  import osd_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [AddrW-1:0] pos;
  logic             last_c;

  osd_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .cfg_we_i, .cfg_wdata_i(updates_per_draw_i),
    .stat_i(stat), .pos_i(pos), .cmd_o(cmd), .last_o(last_c), .busy_o(busy)
  );

  osd_datapath u_dp (
    .clk_i, .rst_ni, .opcode_i, .column_i, .row_i, .char_code_i, .attr_in_i,
    .cmd_i(cmd), .last_i(last_c), .stat_o(stat), .pos_o(pos), .strobe_o(done_o),
    .status_o, .char_out_o, .attr_out_o, .update_valid_o, .mode_write_o,
    .mode_value_o, .extended_write_o, .cell_addr_high_o, .cell_addr_low_o,
    .attr_byte_o, .char_low_o, .last_o
  );

`ifndef SYNTH
  a_status_only_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> last_o && !update_valid_o) else $error("bad status");
  a_mode_with_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && mode_write_o |-> update_valid_o) else $error("mode without update");
  a_idle_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && $past(!busy) |-> !done_o) else $error("result while idle");
`endif

endmodule
`default_nettype wire

>>> tb/tb_osd_dirty_cell_update_engine_unit.sv
`timescale 1ns / 100ps
module tb_osd_dirty_cell_update_engine_unit;
  import osd_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 16;
  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  typedef struct {
    logic       status;
    logic [8:0] char_out;
    logic [7:0] attr_out;
    logic       update_valid;
    logic       mode_write;
    logic [7:0] mode_value;
    logic       extended_write;
    logic       cell_addr_high;
    logic [7:0] cell_addr_low;
    logic [7:0] attr_byte;
    logic [7:0] char_low;
    logic       last;
  } cell_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       cfg_we_i;
  logic [3:0] updates_per_draw_i;
  logic [2:0] opcode_i;
  logic [4:0] column_i;
  logic [4:0] row_i;
  logic [8:0] char_code_i;
  logic [7:0] attr_in_i;
  logic       done_o;
  logic       status_o;
  logic [8:0] char_out_o;
  logic [7:0] attr_out_o;
  logic       update_valid_o;
  logic       mode_write_o;
  logic [7:0] mode_value_o;
  logic       extended_write_o;
  logic       cell_addr_high_o;
  logic [7:0] cell_addr_low_o;
  logic [7:0] attr_byte_o;
  logic [7:0] char_low_o;
  logic       last_o;

  // shadow of the screen store
  logic [15:0] screen_cells [ScreenCells];
  logic        dirty_cells [ScreenCells];
  logic [7:0]  mode_reg;
  logic [3:0]  draw_limit_reg;
  cell_result_t pending_updates[$];

  int unsigned mismatches = 0;
  int unsigned idle_pct = 36;
  int unsigned stall_cycles = 0;

  osd_dirty_cell_update_engine_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cfg_we_i           (cfg_we_i),
    .updates_per_draw_i (updates_per_draw_i),
    .opcode_i           (opcode_i),
    .column_i           (column_i),
    .row_i              (row_i),
    .char_code_i        (char_code_i),
    .attr_in_i          (attr_in_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .char_out_o         (char_out_o),
    .attr_out_o         (attr_out_o),
    .update_valid_o     (update_valid_o),
    .mode_write_o       (mode_write_o),
    .mode_value_o       (mode_value_o),
    .extended_write_o   (extended_write_o),
    .cell_addr_high_o   (cell_addr_high_o),
    .cell_addr_low_o    (cell_addr_low_o),
    .attr_byte_o        (attr_byte_o),
    .char_low_o         (char_low_o),
    .last_o             (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic cell_result_t zero_result();
    cell_result_t r;
    r = '{default: '0};
    return r;
  endfunction

  function automatic logic cell_is_blank(logic [15:0] v);
    return ((v[15:8] == 8'h20) || (v[15:8] == 8'h00)) && (v[2] == 1'b0);
  endfunction

  // compute the expected cell updates of one draw
  task automatic predict_draw();
    int unsigned lim;
    int unsigned sent;
    cell_result_t r;
    logic [7:0] a;
    lim = (draw_limit_reg == 0) ? 1 : (draw_limit_reg > DrawMax) ? DrawMax : draw_limit_reg;
    sent = 0;
    for (int p = 0; p < ScreenCells && sent < lim; p++) begin
      if (!dirty_cells[p]) continue;
      r = zero_result();
      a = screen_cells[p][7:0];
      r.update_valid = 1'b1;
      if (a[2]) begin
        if (!mode_reg[6]) begin
          mode_reg[6] = 1'b1;
          r.mode_write = 1'b1;
          r.mode_value = mode_reg;
        end
        r.extended_write = 1'b1;
        r.attr_byte = a << 2;
      end else if (mode_reg[6] || ((mode_reg & ModeAttrMsk) != a)) begin
        mode_reg = (mode_reg & ~(Mode8Bit | ModeAttrMsk)) | a;
        r.mode_write = 1'b1;
        r.mode_value = mode_reg;
      end
      r.cell_addr_high = p[8];
      r.cell_addr_low = p[7:0];
      r.char_low = screen_cells[p][15:8];
      r.last = (sent + 1 == lim);
      dirty_cells[p] = 1'b0;
      pending_updates.push_back(r);
      sent++;
    end
    if (sent == 0) begin
      r = zero_result();
      r.last = 1'b1;
      pending_updates.push_back(r);
    end else begin
      pending_updates[$].last = 1'b1;
    end
  endtask

  // compute the expected result of one accepted command
  task automatic predict_command(logic [2:0] op, logic [4:0] col, logic [4:0] row,
                                 logic [8:0] chr, logic [7:0] attr);
    cell_result_t r;
    int unsigned p;
    logic [15:0] v;
    p = row * RowLength + col;
    if (op == OpDraw) begin
      predict_draw();
      return;
    end
    r = zero_result();
    r.last = 1'b1;
    if (op == OpWrite || op == OpRead) begin
      if (p >= ScreenCells) begin
        r.status = 1'b1;
      end else if (op == OpWrite) begin
        v = {chr[7:0], attr | ((chr > 255) ? ExtFlag : 8'h00)};
        if (screen_cells[p] != v) begin
          screen_cells[p] = v;
          dirty_cells[p] = 1'b1;
        end
      end else begin
        v = screen_cells[p];
        r.char_out = {v[2], v[15:8]};
        r.attr_out = v[7:0] & ~ExtFlag;
      end
    end else if (op == OpClear) begin
      for (int i = 0; i < ScreenCells; i++) begin
        if (screen_cells[i] != BlankCell) begin
          screen_cells[i] = BlankCell;
          dirty_cells[i] = 1'b1;
        end
      end
    end else if (op == OpRefresh) begin
      for (int i = 0; i < ScreenCells; i++) dirty_cells[i] = !cell_is_blank(screen_cells[i]);
    end
    pending_updates.push_back(r);
  endtask

  // send one command, with random gaps before it
  task automatic send_command(logic [2:0] op, logic [4:0] col, logic [4:0] row,
                              logic [8:0] chr, logic [7:0] attr);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start = 1'b1;
    opcode_i = op;
    column_i = col;
    row_i = row;
    char_code_i = chr;
    attr_in_i = attr;
    do @(posedge clk_i); while (busy);
    predict_command(op, col, row, chr, attr);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_updates.size() != 0 || busy) @(negedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_draw_limit(logic [3:0] value);
    wait_drained();
    cfg_we_i = 1'b1;
    updates_per_draw_i = value;
    @(negedge clk_i);
    draw_limit_reg = value;
    cfg_we_i = 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    cell_result_t e;
    if (rst_ni && done_o) begin
      if (pending_updates.size() == 0) begin
        $error("result with no expectation waiting");
        mismatches++;
      end else begin
        e = pending_updates.pop_front();
        check_field("status", e.status, status_o);
        check_field("char_out", e.char_out, char_out_o);
        check_field("attr_out", e.attr_out, attr_out_o);
        check_field("update_valid", e.update_valid, update_valid_o);
        check_field("mode_write", e.mode_write, mode_write_o);
        check_field("mode_value", e.mode_value, mode_value_o);
        check_field("extended_write", e.extended_write, extended_write_o);
        check_field("cell_addr_high", e.cell_addr_high, cell_addr_high_o);
        check_field("cell_addr_low", e.cell_addr_low, cell_addr_low_o);
        check_field("attr_byte", e.attr_byte, attr_byte_o);
        check_field("char_low", e.char_low, char_low_o);
        check_field("last", e.last, last_o);
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_reset_state();
    send_command(OpRead, 5'd0, 5'd0, 9'h0, 8'h0);
    send_command(OpRead, 5'd29, 5'd15, 9'h0, 8'h0);
    send_command(OpDraw, 5'd0, 5'd0, 9'h0, 8'h0);
  endtask

  task automatic test_write_read();
    send_command(OpWrite, 5'd0, 5'd0, 9'h041, 8'h00);
    send_command(OpWrite, 5'd0, 5'd0, 9'h041, 8'h00);
    send_command(OpWrite, 5'd29, 5'd15, 9'h1ff, 8'hff);
    send_command(OpWrite, 5'd31, 5'd0, 9'h000, 8'h04);
    send_command(OpWrite, 5'd1, 5'd1, 9'h120, 8'h38);
    send_command(OpRead, 5'd29, 5'd15, 9'h1ff, 8'hff);
    send_command(OpRead, 5'd31, 5'd0, 9'h0, 8'h0);
    send_command(OpRead, 5'd1, 5'd1, 9'h0, 8'h0);
  endtask

  task automatic test_out_of_range();
    send_command(OpWrite, 5'd30, 5'd15, 9'h055, 8'h11);
    send_command(OpRead, 5'd31, 5'd31, 9'h0, 8'h0);
    send_command(OpWrite, 5'd31, 5'd31, 9'h1aa, 8'haa);
  endtask

  task automatic test_draw_modes();
    send_command(OpDraw, 5'd0, 5'd0, 9'h0, 8'h0);
    send_command(OpWrite, 5'd2, 5'd0, 9'h042, 8'h08);
    send_command(OpWrite, 5'd3, 5'd0, 9'h043, 8'h08);
    send_command(OpDraw, 5'd0, 5'd0, 9'h0, 8'h0);
    send_command(OpDraw, 5'd0, 5'd0, 9'h0, 8'h0);
  endtask

  task automatic test_clear_refresh();
    send_command(OpRefresh, 5'd0, 5'd0, 9'h0, 8'h0);
    send_command(OpDraw, 5'd0, 5'd0, 9'h0, 8'h0);
    send_command(OpClear, 5'd0, 5'd0, 9'h0, 8'h0);
    send_command(OpDraw, 5'd0, 5'd0, 9'h0, 8'h0);
  endtask

  task automatic test_unused_opcodes();
    for (logic [3:0] op = OpUnusedLo; op <= OpUnusedHi; op++) begin
      send_command(op[2:0], 5'h1f, 5'h1f, 9'h1ff, 8'hff);
    end
  endtask

  // fill a few cells so that draws under each limit have work to do
  task automatic test_draw_limits();
    logic [3:0] limits [4] = '{4'd0, 4'd15, 4'd1, 4'd10};
    foreach (limits[k]) begin
      write_draw_limit(limits[k]);
      for (int i = 0; i < 12; i++) begin
        send_command(OpWrite, 5'($urandom_range(29)), 5'($urandom_range(3)),
                     9'($urandom), 8'($urandom));
      end
      send_command(OpDraw, 5'd0, 5'd0, 9'h0, 8'h0);
      send_command(OpDraw, 5'd0, 5'd0, 9'h0, 8'h0);
    end
  endtask

  task automatic test_random(int unsigned count);
    int unsigned pick;
    logic [2:0] op;
    logic [4:0] col;
    logic [4:0] row;
    for (int n = 0; n < count; n++) begin
      // no idling for a stretch in the middle
      idle_pct = (n >= count / 3 && n < count / 2) ? 0 : 36;
      if (n % 40 == 39) wait_drained();
      if (n == count / 2) write_draw_limit(4'($urandom_range(1, 15)));
      pick = $urandom_range(99);
      if (pick < 45) op = OpWrite;
      else if (pick < 65) op = OpRead;
      else if (pick < 88) op = OpDraw;
      else if (pick < 92) op = OpClear;
      else if (pick < 96) op = OpRefresh;
      else op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
      // mostly a small corner of the screen so cells are reused
      if ($urandom_range(3) == 0) begin
        col = 5'($urandom);
        row = 5'($urandom);
      end else begin
        col = 5'($urandom_range(7));
        row = 5'($urandom_range(2));
      end
      send_command(op, col, row, 9'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    updates_per_draw_i = DrawMax;
    opcode_i = OpWrite;
    column_i = '0;
    row_i = '0;
    char_code_i = '0;
    attr_in_i = '0;
    foreach (screen_cells[i]) begin
      screen_cells[i] = BlankCell;
      dirty_cells[i] = 1'b0;
    end
    mode_reg = '0;
    draw_limit_reg = DrawMax;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_write_read();
    test_out_of_range();
    test_draw_modes();
    test_clear_refresh();
    test_unused_opcodes();
    test_draw_limits();
    test_random(48);

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
